/* rtl/uft_pkg.sv */
// Shared types and constants for the URL / form-urlencoded decoding tokenizer.
package uft_pkg;

    // Most results a single input byte can produce: a delimiter, fragment begin,
    // fragment end and string end.
    localparam int unsigned MAX_TOKENS = 4;
    localparam int unsigned CNT_W      = $clog2(MAX_TOKENS + 1);
    localparam int unsigned IDX_W      = $clog2(MAX_TOKENS);

    // Configuration register indexes.
    localparam logic REG_BODY_MODE = 1'b0;

    // Character codes.
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        TK_DATA       = 3'd0,
        TK_PATH_END   = 3'd1,
        TK_NAME_END   = 3'd2,
        TK_PAIR_END   = 3'd3,
        TK_FRAG_BEGIN = 3'd4,
        TK_FRAG_END   = 3'd5,
        TK_STR_END    = 3'd6,
        TK_MALFORMED  = 3'd7
    } token_kind_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } esc_phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_byte;
    } req_t;

    typedef struct packed {
        logic [2:0] token_kind;
        logic [7:0] out_byte;
        logic       run_last;
    } rsp_t;

    typedef struct packed {
        esc_phase_t escape_phase;
        logic [3:0] high_nibble;
        logic       in_fragment;
        logic       value_nonempty;
        logic       name_nonempty;
        logic       path_nonempty;
        logic       discarding;
    } parse_state_t;

    // All tokens caused by one input byte. Only the first token can be data.
    typedef struct packed {
        token_kind_t [MAX_TOKENS-1:0] kinds;
        logic [7:0]                   data_byte;
        logic [CNT_W-1:0]             count;
    } bundle_t;

    // Returns {valid, value} for an ASCII hex digit.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            return {1'b1, d[3:0]};
        end
        if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            return {1'b1, d[3:0]};
        end
        if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

/* rtl/url_form_decode_tokenizer.sv */
// Top level of the URL / form-urlencoded decoding tokenizer.
// Each request carries one byte of a URI or form body; the block answers with
// one to four token responses (decoded data, delimiter events, string end or a
// malformed escape), the last of them flagged by run_last, and some bytes cause
// no response. A byte is registered on acceptance, decoded against the parse
// state, and its token bundle goes into a two-entry queue that drains one token per
// cycle while rsp_ready is high. It then sustains one request per cycle while each
// byte yields at most one token; a byte with k tokens holds the response side until
// all k are taken, and requests keep flowing until both queue entries are occupied.
// The body_mode register sits at APB address 0 and must be written only while idle.
module url_form_decode_tokenizer
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  uft_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output uft_pkg::rsp_t  rsp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    logic             body_mode_reg;
    logic             in_v_reg;
    uft_pkg::req_t    in_reg;
    logic             q_full;
    logic             fire;
    uft_pkg::bundle_t bundle;

    // The register index is the word address.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == uft_pkg::REG_BODY_MODE) ? {31'd0, body_mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && paddr[2] == uft_pkg::REG_BODY_MODE)
        begin
            body_mode_reg <= pwdata[0];
        end
    end

    assign fire      = in_v_reg && !q_full;
    assign req_ready = !in_v_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            in_v_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            in_reg <= req;
        end
    end

    uft_decoder u_decoder
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .body_mode (body_mode_reg),
        .req_in    (in_reg),
        .bundle    (bundle)
    );

    uft_token_queue u_queue
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (fire && bundle.count != '0),
        .push_bundle (bundle),
        .full        (q_full),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp)
    );

endmodule

/* rtl/uft_decoder.sv */
// Per-string parse state and the single-pass decode of one byte into a token bundle.
module uft_decoder
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic                  body_mode,
    input  uft_pkg::req_t         req_in,
    output uft_pkg::bundle_t      bundle
);

    uft_pkg::parse_state_t st_reg;
    uft_pkg::parse_state_t st_next;
    logic [uft_pkg::CNT_W-1:0] n;
    logic [4:0] hv;
    logic       bad;
    logic [7:0] b;
    logic       fin;

    assign b   = req_in.in_byte;
    assign fin = req_in.final_byte;
    assign hv  = uft_pkg::hex_nibble(b);

    always_comb
    begin
        st_next = st_reg;
        bundle  = '0;
        n       = '0;
        bad     = 1'b0;
        if (st_reg.discarding)
        begin
            if (fin)
            begin
                st_next = '0;
            end
        end
        else
        begin
            if (st_reg.in_fragment)
            begin
                bundle.kinds[n[uft_pkg::IDX_W-1:0]] = uft_pkg::TK_DATA;
                bundle.data_byte = b;
                n = n + 1'b1;
                st_next.value_nonempty = 1'b1;
            end
            else
            begin
                case (st_reg.escape_phase)
                    uft_pkg::PH_HIGH:
                    begin
                        if (!hv[4] || fin)
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            st_next.high_nibble  = hv[3:0];
                            st_next.escape_phase = uft_pkg::PH_LOW;
                        end
                    end
                    uft_pkg::PH_LOW:
                    begin
                        if (!hv[4])
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            st_next.escape_phase = uft_pkg::PH_IDLE;
                            bundle.kinds[n[uft_pkg::IDX_W-1:0]] = uft_pkg::TK_DATA;
                            bundle.data_byte = {st_reg.high_nibble, hv[3:0]};
                            n = n + 1'b1;
                            st_next.value_nonempty = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (b == uft_pkg::CH_PLUS)
                        begin
                            bundle.kinds[n[uft_pkg::IDX_W-1:0]] = uft_pkg::TK_DATA;
                            bundle.data_byte = uft_pkg::CH_SPACE;
                            n = n + 1'b1;
                            st_next.value_nonempty = 1'b1;
                        end
                        else if (b == uft_pkg::CH_PCT)
                        begin
                            st_next.escape_phase = uft_pkg::PH_HIGH;
                            bad = fin;
                        end
                        else if (b == uft_pkg::CH_QMARK && !body_mode)
                        begin
                            bundle.kinds[n[uft_pkg::IDX_W-1:0]] = uft_pkg::TK_PATH_END;
                            n = n + 1'b1;
                            st_next.path_nonempty  = st_next.value_nonempty;
                            st_next.value_nonempty = 1'b0;
                        end
                        else if (b == uft_pkg::CH_EQ)
                        begin
                            bundle.kinds[n[uft_pkg::IDX_W-1:0]] = uft_pkg::TK_NAME_END;
                            n = n + 1'b1;
                            st_next.name_nonempty  = st_next.value_nonempty;
                            st_next.value_nonempty = 1'b0;
                        end
                        else if (b == uft_pkg::CH_AMP)
                        begin
                            bundle.kinds[n[uft_pkg::IDX_W-1:0]] = uft_pkg::TK_PAIR_END;
                            n = n + 1'b1;
                            st_next.name_nonempty  = 1'b0;
                            st_next.value_nonempty = 1'b0;
                        end
                        else if (b == uft_pkg::CH_HASH && !body_mode)
                        begin
                            if (!st_next.path_nonempty)
                            begin
                                bundle.kinds[n[uft_pkg::IDX_W-1:0]] = uft_pkg::TK_PATH_END;
                                st_next.path_nonempty = st_next.value_nonempty;
                            end
                            else
                            begin
                                bundle.kinds[n[uft_pkg::IDX_W-1:0]] = uft_pkg::TK_PAIR_END;
                                st_next.name_nonempty = 1'b0;
                            end
                            st_next.value_nonempty = 1'b0;
                            n = n + 1'b1;
                            bundle.kinds[n[uft_pkg::IDX_W-1:0]] = uft_pkg::TK_FRAG_BEGIN;
                            n = n + 1'b1;
                            st_next.in_fragment = 1'b1;
                        end
                        else
                        begin
                            bundle.kinds[n[uft_pkg::IDX_W-1:0]] = uft_pkg::TK_DATA;
                            bundle.data_byte = b;
                            n = n + 1'b1;
                            st_next.value_nonempty = 1'b1;
                        end
                    end
                endcase
            end

            if (bad)
            begin
                bundle.kinds[n[uft_pkg::IDX_W-1:0]] = uft_pkg::TK_MALFORMED;
                n = n + 1'b1;
                if (fin)
                begin
                    st_next = '0;
                end
                else
                begin
                    st_next.discarding = 1'b1;
                end
            end
            else if (fin)
            begin
                // Close whatever the string left open, then mark its end.
                if (st_next.in_fragment)
                begin
                    bundle.kinds[n[uft_pkg::IDX_W-1:0]] = uft_pkg::TK_FRAG_END;
                    n = n + 1'b1;
                end
                else if (!body_mode && !st_next.path_nonempty)
                begin
                    bundle.kinds[n[uft_pkg::IDX_W-1:0]] = uft_pkg::TK_PATH_END;
                    n = n + 1'b1;
                end
                else if (st_next.name_nonempty)
                begin
                    bundle.kinds[n[uft_pkg::IDX_W-1:0]] = uft_pkg::TK_PAIR_END;
                    n = n + 1'b1;
                end
                bundle.kinds[n[uft_pkg::IDX_W-1:0]] = uft_pkg::TK_STR_END;
                n = n + 1'b1;
                st_next = '0;
            end
        end
        bundle.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (fire)
        begin
            st_reg <= st_next;
        end
    end

endmodule

/* rtl/uft_token_queue.sv */
// Two-entry token bundle queue that hands out one token per response request.
module uft_token_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  uft_pkg::bundle_t  push_bundle,
    output logic              full,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output uft_pkg::rsp_t     rsp
);

    uft_pkg::bundle_t           head_reg;
    uft_pkg::bundle_t           tail_reg;
    logic                       head_v_reg;
    logic                       tail_v_reg;
    logic [uft_pkg::IDX_W-1:0]  idx_reg;
    logic [uft_pkg::IDX_W-1:0]  idx_next;
    logic                       last;
    logic                       take;
    logic                       pop;

    assign full      = tail_v_reg;
    assign rsp_valid = head_v_reg;
    assign last      = ({1'b0, idx_reg} == (head_reg.count - 1'b1));
    assign take      = head_v_reg && rsp_ready;
    assign pop       = take && last;

    always_comb
    begin
        rsp.token_kind = head_reg.kinds[idx_reg];
        rsp.out_byte   = (head_reg.kinds[idx_reg] == uft_pkg::TK_DATA) ?
                         head_reg.data_byte : 8'h00;
        rsp.run_last   = last;
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (pop)
        begin
            idx_next = '0;
        end
        else if (take)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_v_reg <= 1'b0;
            tail_v_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (pop)
            begin
                if (tail_v_reg)
                begin
                    tail_v_reg <= 1'b0;
                end
                else
                begin
                    head_v_reg <= push;
                end
            end
            else if (push)
            begin
                if (!head_v_reg)
                begin
                    head_v_reg <= 1'b1;
                end
                else
                begin
                    tail_v_reg <= 1'b1;
                end
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (tail_v_reg)
            begin
                head_reg <= tail_reg;
            end
            else if (push)
            begin
                head_reg <= push_bundle;
            end
        end
        else if (push)
        begin
            if (!head_v_reg)
            begin
                head_reg <= push_bundle;
            end
            else
            begin
                tail_reg <= push_bundle;
            end
        end
    end

endmodule

/* rtl/uft_checker.sv */
// Port-level checks for the tokenizer, bound to its top level.
module uft_checker
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           rsp_valid,
    input  logic           rsp_ready,
    input  uft_pkg::rsp_t  rsp
);

    // A response that waits keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // Only data tokens carry a byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.token_kind != uft_pkg::TK_DATA |-> rsp.out_byte == 8'h00)
        else $error("non-data token with nonzero byte");

    // A run of tokens from one byte comes out without a gap.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && !rsp.run_last |=> rsp_valid)
        else $error("token run broken");

    // String end and malformed escape always close the run for their byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.token_kind == uft_pkg::TK_STR_END ||
                      rsp.token_kind == uft_pkg::TK_MALFORMED) |-> rsp.run_last)
        else $error("terminal token without run_last");

endmodule

bind url_form_decode_tokenizer uft_checker u_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

/* test/token_check_pkg.sv */
`timescale 1ns / 1ps
// Token predictor and scoreboard for the URL / form-urlencoded tokenizer testbench.
package token_check_pkg;

    class token_checker;

        // Predicted parse state, mirrored from the block's behavior.
        bit                  body_mode;
        uft_pkg::esc_phase_t phase;
        logic [3:0]          hi_nib;
        bit                  in_frag;
        bit                  val_ne;
        bit                  name_ne;
        bit                  path_ne;
        bit                  discard;

        uft_pkg::rsp_t       expected_tokens[$];
        int                  step_tokens;
        int                  errors;

        function new();
            body_mode = 1'b0;
            errors    = 0;
            clear_string();
        endfunction

        function void set_mode(bit mode);
            body_mode = mode;
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        function void clear_string();
            phase   = uft_pkg::PH_IDLE;
            hi_nib  = 4'h0;
            in_frag = 1'b0;
            val_ne  = 1'b0;
            name_ne = 1'b0;
            path_ne = 1'b0;
            discard = 1'b0;
        endfunction

        function int hex_value(logic [7:0] c);
            if (c >= 8'h30 && c <= 8'h39)
            begin
                return int'(c - 8'h30);
            end
            if (c >= 8'h61 && c <= 8'h66)
            begin
                return int'(c - 8'h61) + 10;
            end
            if (c >= 8'h41 && c <= 8'h46)
            begin
                return int'(c - 8'h41) + 10;
            end
            return -1;
        endfunction

        function void emit(uft_pkg::token_kind_t kind, logic [7:0] b);
            uft_pkg::rsp_t t;
            t.token_kind    = kind;
            t.out_byte      = b;
            t.run_last      = 1'b0;
            expected_tokens = {expected_tokens, t};
            step_tokens++;
        endfunction

        function void data_tok(logic [7:0] b);
            emit(uft_pkg::TK_DATA, b);
            val_ne = 1'b1;
        endfunction

        function void close_path();
            emit(uft_pkg::TK_PATH_END, 8'h00);
            path_ne = val_ne;
            val_ne  = 1'b0;
        endfunction

        function void close_pair();
            emit(uft_pkg::TK_PAIR_END, 8'h00);
            name_ne = 1'b0;
            val_ne  = 1'b0;
        endfunction

        // Works out every token that one accepted request byte causes.
        function void predict_byte(uft_pkg::req_t r);
            logic [7:0]    b;
            bit            fin;
            bit            bad;
            int            h;
            uft_pkg::rsp_t tail;
            b           = r.in_byte;
            fin         = r.final_byte;
            bad         = 1'b0;
            step_tokens = 0;

            // A broken escape swallows the rest of the string, up to its final byte.
            if (discard)
            begin
                if (fin)
                begin
                    clear_string();
                end
                return;
            end

            if (in_frag)
            begin
                data_tok(b);
            end
            else if (phase == uft_pkg::PH_HIGH)
            begin
                h = hex_value(b);
                if (h < 0 || fin)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    hi_nib = h[3:0];
                    phase  = uft_pkg::PH_LOW;
                end
            end
            else if (phase == uft_pkg::PH_LOW)
            begin
                h = hex_value(b);
                if (h < 0)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    phase = uft_pkg::PH_IDLE;
                    data_tok({hi_nib, h[3:0]});
                end
            end
            else if (b == uft_pkg::CH_PLUS)
            begin
                data_tok(uft_pkg::CH_SPACE);
            end
            else if (b == uft_pkg::CH_PCT)
            begin
                phase = uft_pkg::PH_HIGH;
                if (fin)
                begin
                    bad = 1'b1;
                end
            end
            else if (b == uft_pkg::CH_QMARK && !body_mode)
            begin
                close_path();
            end
            else if (b == uft_pkg::CH_EQ)
            begin
                emit(uft_pkg::TK_NAME_END, 8'h00);
                name_ne = val_ne;
                val_ne  = 1'b0;
            end
            else if (b == uft_pkg::CH_AMP)
            begin
                close_pair();
            end
            else if (b == uft_pkg::CH_HASH && !body_mode)
            begin
                if (!path_ne)
                begin
                    close_path();
                end
                else
                begin
                    close_pair();
                end
                emit(uft_pkg::TK_FRAG_BEGIN, 8'h00);
                in_frag = 1'b1;
            end
            else
            begin
                data_tok(b);
            end

            if (bad)
            begin
                emit(uft_pkg::TK_MALFORMED, 8'h00);
                if (fin)
                begin
                    clear_string();
                end
                else
                begin
                    discard = 1'b1;
                end
            end
            else if (fin)
            begin
                if (in_frag)
                begin
                    emit(uft_pkg::TK_FRAG_END, 8'h00);
                end
                else if (!body_mode && !path_ne)
                begin
                    close_path();
                end
                else if (name_ne)
                begin
                    close_pair();
                end
                emit(uft_pkg::TK_STR_END, 8'h00);
                clear_string();
            end

            if (step_tokens > 0)
            begin
                tail          = expected_tokens[expected_tokens.size() - 1];
                tail.run_last = 1'b1;
                expected_tokens[expected_tokens.size() - 1] = tail;
            end
        endfunction

        task check_token(uft_pkg::rsp_t got);
            uft_pkg::rsp_t want;
            if (expected_tokens.size() == 0)
            begin
                report($sformatf("token kind %0d byte %02h with nothing expected",
                                 got.token_kind, got.out_byte));
                return;
            end
            want = expected_tokens.pop_front();
            if (got.token_kind !== want.token_kind)
            begin
                report($sformatf("token_kind %0d, expected %0d",
                                 got.token_kind, want.token_kind));
            end
            if (got.out_byte !== want.out_byte)
            begin
                report($sformatf("out_byte %02h, expected %02h (kind %0d)",
                                 got.out_byte, want.out_byte, want.token_kind));
            end
            if (got.run_last !== want.run_last)
            begin
                report($sformatf("run_last %0b, expected %0b (kind %0d)",
                                 got.run_last, want.run_last, want.token_kind));
            end
        endtask

    endclass

endpackage

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Top-level testbench for the URL / form-urlencoded decoding tokenizer.
module tb_top;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 80;

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_ready;
    uft_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_ready;
    uft_pkg::rsp_t rsp;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    token_check_pkg::token_checker sb;
    logic [7:0]   text_bytes[$];
    bit           no_idle;
    int           cycle_count;

    url_form_decode_tokenizer i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Both handshakes are observed here; a response never stems from a request
    // accepted at the same edge, so the order of the two calls does not matter.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                sb.check_token(rsp);
            end
            if (req_valid && req_ready)
            begin
                sb.predict_byte(req);
            end
        end
    end

    // Response side: a random stall before each token, none while no_idle is set.
    initial
    begin
        int gap;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 7);
            if (gap != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
            @(negedge clk);
        end
    end

    task automatic send_byte(logic [7:0] b, bit fin);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= {b, fin};
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
    endtask

    task automatic send_text(bit with_final);
        for (int i = 0; i < text_bytes.size(); i++)
        begin
            send_byte(text_bytes[i], with_final && (i == text_bytes.size() - 1));
        end
        text_bytes.delete();
    endtask

    task automatic append_byte(logic [7:0] b);
        text_bytes = {text_bytes, b};
    endtask

    task automatic append_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            append_byte(s[i]);
        end
    endtask

    // Holds off new requests until every predicted token has come, then lets the
    // block settle in case a byte with no tokens is in flight.
    task automatic wait_drain();
        req_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_body_mode(bit mode);
        logic [31:0] wdata;
        wait_drain();
        wdata    = $urandom;
        wdata[0] = mode;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {uft_pkg::REG_BODY_MODE, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_mode(mode);
        // Read the register back right away.
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[0] !== mode)
        begin
            sb.report($sformatf("body_mode reads %0b, expected %0b", prdata[0], mode));
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [7:0] random_hex_char();
        int k;
        k = $urandom_range(0, 21);
        if (k < 10)
        begin
            return 8'(8'h30 + k);
        end
        if (k < 16)
        begin
            return 8'(8'h61 + k - 10);
        end
        return 8'(8'h41 + k - 16);
    endfunction

    // Mostly well-formed strings with random content, plus raw noise and strings
    // with a broken or truncated escape.
    task automatic run_random(int n_items, bit pause_mid);
        int sent;
        bit paused;
        int pick;
        int len;
        int k;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_items)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            pick    = $urandom_range(0, 9);
            if (pick == 7 || pick == 8)
            begin
                len = $urandom_range(1, 8);
                repeat (len) append_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                len = $urandom_range(1, 6);
                repeat (len)
                begin
                    k = $urandom_range(0, 9);
                    case (k)
                        0, 1, 2: append_byte(8'($urandom_range(8'h61, 8'h7a)));
                        3:       append_byte(uft_pkg::CH_PLUS);
                        4, 5:
                        begin
                            append_byte(uft_pkg::CH_PCT);
                            append_byte(random_hex_char());
                            append_byte(random_hex_char());
                        end
                        6:       append_byte(uft_pkg::CH_EQ);
                        7:       append_byte(uft_pkg::CH_AMP);
                        8:       append_byte(uft_pkg::CH_QMARK);
                        default: append_byte(uft_pkg::CH_HASH);
                    endcase
                end
                if (pick == 9)
                begin
                    append_byte(uft_pkg::CH_PCT);
                    k = $urandom_range(0, 3);
                    if (k >= 2)
                    begin
                        append_byte(random_hex_char());
                    end
                    if (k == 0 || k == 3)
                    begin
                        append_byte(8'($urandom_range(8'h67, 8'h7a)));
                        repeat ($urandom_range(0, 3))
                            append_byte(8'($urandom_range(0, 255)));
                    end
                end
            end
            sent += text_bytes.size();
            send_text(1'b1);
            if (pause_mid && !paused && sent >= n_items / 2)
            begin
                paused = 1'b1;
                wait_drain();
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        sb          = new();
        cycle_count = 0;
        no_idle     = 1'b0;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // URI mode: escapes, path end, name end, plus, pair end and a raw fragment.
        append_text("%4f?n=+&#x");
        send_text(1'b1);
        // A lone hash with an empty path gives four tokens.
        append_text("#");
        send_text(1'b1);
        // Strings that end inside an escape.
        append_text("%");
        send_text(1'b1);
        append_text("%F");
        send_text(1'b1);
        // A non-hex digit after the percent sign discards the rest of the string.
        append_text("%z");
        append_byte(8'hFF);
        send_text(1'b1);
        // Open a fragment and leave the string unfinished across a mode change.
        append_byte(8'h00);
        append_text("#");
        send_text(1'b0);

        write_body_mode(1'b1);
        append_text("?");
        send_text(1'b1);
        append_text("#=%7e");
        send_text(1'b1);
        // Bad low digit on the final byte.
        append_text("%Ag");
        send_text(1'b1);

        write_body_mode(1'b0);
        run_random(RANDOM_ITEMS / 3, 1'b1);
        write_body_mode(1'b1);
        run_random(RANDOM_ITEMS / 3, 1'b0);
        write_body_mode(1'b0);
        run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 1'b0);
        wait_drain();

        if (sb.errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* url_form_decode_tokenizer.f */
rtl/uft_pkg.sv
rtl/uft_decoder.sv
rtl/uft_token_queue.sv
rtl/url_form_decode_tokenizer.sv
rtl/uft_checker.sv
test/token_check_pkg.sv
test/tb_top.sv
